// ===== rtl/dkc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dkc_pkg;

    localparam int N_DET   = 4;
    localparam int OFF_W   = 10;
    localparam int SLOPE_W = 24;
    localparam int RAD_W   = 34;
    localparam int CNT_W   = 18;

    localparam logic [OFF_W-1:0] SAT_LEVEL = 10'd1023;

    // Data that travels beside the dividers until the knee counts are summed.
    typedef struct packed {
        logic [N_DET-1:0][RAD_W-1:0] rad;
        logic [N_DET-1:0][OFF_W-1:0] sc;
        logic [2:0]                  zf;
    } t_side;

endpackage

`default_nettype wire

// ===== rtl/detector_knee_calibration.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Detector knee calibration.
// Input channel: i_valid with the four offsets and four slopes of one band
// and gain; a word is taken at a clock edge where i_valid is high and o_stall
// is low. Output channel: o_valid with four sorted knee radiances, four knee
// counts and the zero slope flag; a word leaves at an edge where o_valid is
// high and i_stall is low.
// The block is one pipeline: a multiply stage, a sort stage, a divider load
// stage, one restoring divider stage per quotient bit (10 + COUNT_FRAC_BITS),
// and a summing output stage. A new word can enter in every cycle in which
// o_stall is low.
// Six dividers run side by side, one for each quotient the knee counts need.
// When the receiver stalls while a result waits, the whole pipeline holds and
// o_stall rises; every stage keeps its contents, empty slots included, and a
// new word is taken as long as the output register is free or being emptied.
// Reset, synchronous and active low, clears every valid bit; data registers
// are not reset.
module detector_knee_calibration import dkc_pkg::*; #(
    parameter int COUNT_FRAC_BITS = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  [OFF_W-1:0]    i_offset_det0,
    input  wire  [OFF_W-1:0]    i_offset_det1,
    input  wire  [OFF_W-1:0]    i_offset_det2,
    input  wire  [OFF_W-1:0]    i_offset_det3,
    input  wire  [SLOPE_W-1:0]  i_slope_det0,
    input  wire  [SLOPE_W-1:0]  i_slope_det1,
    input  wire  [SLOPE_W-1:0]  i_slope_det2,
    input  wire  [SLOPE_W-1:0]  i_slope_det3,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [RAD_W-1:0]    o_knee_radiance_1,
    output logic [RAD_W-1:0]    o_knee_radiance_2,
    output logic [RAD_W-1:0]    o_knee_radiance_3,
    output logic [RAD_W-1:0]    o_knee_radiance_4,
    output logic [CNT_W-1:0]    o_knee_count_1,
    output logic [CNT_W-1:0]    o_knee_count_2,
    output logic [CNT_W-1:0]    o_knee_count_3,
    output logic [CNT_W-1:0]    o_knee_count_4,
    output logic                o_zero_slope_flag
);

    localparam int QW = OFF_W + COUNT_FRAC_BITS;
    localparam int SW = QW + 2;
    localparam int ND = 6;

    // The pipeline moves unless a finished word sits at the output and the
    // receiver holds it.
    logic en;
    logic r_vld_out;

    assign en      = !r_vld_out || !i_stall;
    assign o_stall = !en;

    // Stage one: saturation count and saturation radiance per detector.
    logic [OFF_W-1:0]   in_off [N_DET];
    logic [SLOPE_W-1:0] in_g   [N_DET];

    always_comb begin
        in_off[0] = i_offset_det0;
        in_off[1] = i_offset_det1;
        in_off[2] = i_offset_det2;
        in_off[3] = i_offset_det3;
        in_g[0]   = i_slope_det0;
        in_g[1]   = i_slope_det1;
        in_g[2]   = i_slope_det2;
        in_g[3]   = i_slope_det3;
    end

    logic               r_s1_vld;
    logic [OFF_W-1:0]   r_s1_sc  [N_DET];
    logic [SLOPE_W-1:0] r_s1_g   [N_DET];
    logic [RAD_W-1:0]   r_s1_rad [N_DET];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < N_DET; i++) begin
                r_s1_sc[i]  <= SAT_LEVEL - in_off[i];
                r_s1_g[i]   <= in_g[i];
                r_s1_rad[i] <= RAD_W'((SAT_LEVEL - in_off[i]) * in_g[i]);
            end
        end
    end

    // Stage two: stable ascending sort by rank. A detector's rank counts the
    // detectors with a smaller radiance, or an equal one and a lower index.
    logic [1:0]         rank   [N_DET];
    logic [RAD_W-1:0]   so_rad [N_DET];
    logic [OFF_W-1:0]   so_sc  [N_DET];
    logic [SLOPE_W-1:0] so_g   [N_DET];

    always_comb begin
        for (int i = 0; i < N_DET; i++) begin
            rank[i] = '0;
            for (int j = 0; j < N_DET; j++) begin
                if ((r_s1_rad[j] < r_s1_rad[i]) ||
                    ((r_s1_rad[j] == r_s1_rad[i]) && (j < i))) begin
                    rank[i] = rank[i] + 2'd1;
                end
            end
        end
        for (int p = 0; p < N_DET; p++) begin
            so_rad[p] = '0;
            so_sc[p]  = '0;
            so_g[p]   = '0;
            for (int i = 0; i < N_DET; i++) begin
                if (rank[i] == 2'(p)) begin
                    so_rad[p] = so_rad[p] | r_s1_rad[i];
                    so_sc[p]  = so_sc[p]  | r_s1_sc[i];
                    so_g[p]   = so_g[p]   | r_s1_g[i];
                end
            end
        end
    end

    logic               r_s2_vld;
    logic [RAD_W-1:0]   r_s2_rad [N_DET];
    logic [OFF_W-1:0]   r_s2_sc  [N_DET];
    logic [SLOPE_W-1:0] r_s2_g   [1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int p = 0; p < N_DET; p++) begin
                r_s2_rad[p] <= so_rad[p];
                r_s2_sc[p]  <= so_sc[p];
            end
            for (int p = 1; p < N_DET; p++) begin
                r_s2_g[p] <= so_g[p];
            end
        end
    end

    // Divider array. Each quotient divides a smaller radiance by the slope of
    // a later detector, so it never exceeds that detector's saturation count.
    logic [RAD_W-1:0]   dvd [ND];
    logic [SLOPE_W-1:0] dsr [ND];
    logic [QW-1:0]      quo [ND];

    always_comb begin
        dvd[0] = r_s2_rad[0]; dsr[0] = r_s2_g[1];
        dvd[1] = r_s2_rad[0]; dsr[1] = r_s2_g[2];
        dvd[2] = r_s2_rad[0]; dsr[2] = r_s2_g[3];
        dvd[3] = r_s2_rad[1]; dsr[3] = r_s2_g[2];
        dvd[4] = r_s2_rad[1]; dsr[4] = r_s2_g[3];
        dvd[5] = r_s2_rad[2]; dsr[5] = r_s2_g[3];
    end

    for (genvar d = 0; d < ND; d++) begin : g_div
        dkc_div #(
            .CFB (COUNT_FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_dvd (dvd[d]),
            .i_dsr (dsr[d]),
            .o_quo (quo[d])
        );
    end

    // Side data and valid bits delayed to match the dividers.
    t_side n_side;
    t_side r_side [0:QW];
    logic  r_vld_d [0:QW];

    always_comb begin
        for (int p = 0; p < N_DET; p++) begin
            n_side.rad[p] = r_s2_rad[p];
            n_side.sc[p]  = r_s2_sc[p];
        end
        n_side.zf[0] = (r_s2_g[1] == '0);
        n_side.zf[1] = (r_s2_g[2] == '0);
        n_side.zf[2] = (r_s2_g[3] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_vld_d[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld_d[0] <= r_s2_vld;
            for (int k = 1; k <= QW; k++) begin
                r_vld_d[k] <= r_vld_d[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            for (int k = 1; k <= QW; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Output stage: a zero slope replaces its quotient with the saturated
    // count, then each knee count is a sum of four terms divided by four.
    t_side         sd;
    logic [QW-1:0] qe  [ND];
    logic [QW-1:0] sh  [N_DET];
    logic [SW-1:0] sum [N_DET];

    assign sd = r_side[QW];

    always_comb begin
        qe[0] = sd.zf[0] ? (QW'(SAT_LEVEL) << COUNT_FRAC_BITS) : quo[0];
        qe[1] = sd.zf[1] ? (QW'(SAT_LEVEL) << COUNT_FRAC_BITS) : quo[1];
        qe[2] = sd.zf[2] ? (QW'(SAT_LEVEL) << COUNT_FRAC_BITS) : quo[2];
        qe[3] = sd.zf[1] ? (QW'(SAT_LEVEL) << COUNT_FRAC_BITS) : quo[3];
        qe[4] = sd.zf[2] ? (QW'(SAT_LEVEL) << COUNT_FRAC_BITS) : quo[4];
        qe[5] = sd.zf[2] ? (QW'(SAT_LEVEL) << COUNT_FRAC_BITS) : quo[5];
        for (int p = 0; p < N_DET; p++) begin
            sh[p] = QW'(sd.sc[p]) << COUNT_FRAC_BITS;
        end
        sum[0] = SW'(sh[0]) + SW'(qe[0]) + SW'(qe[1]) + SW'(qe[2]);
        sum[1] = SW'(sh[0]) + SW'(sh[1]) + SW'(qe[3]) + SW'(qe[4]);
        sum[2] = SW'(sh[0]) + SW'(sh[1]) + SW'(sh[2]) + SW'(qe[5]);
        sum[3] = SW'(sh[0]) + SW'(sh[1]) + SW'(sh[2]) + SW'(sh[3]);
    end

    logic [RAD_W-1:0] r_out_rad [N_DET];
    logic [CNT_W-1:0] r_out_cnt [N_DET];
    logic             r_out_zf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_out <= 1'b0;
        end else if (en) begin
            r_vld_out <= r_vld_d[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int p = 0; p < N_DET; p++) begin
                r_out_rad[p] <= sd.rad[p];
                r_out_cnt[p] <= CNT_W'(sum[p] >> 2);
            end
            r_out_zf <= |sd.zf;
        end
    end

    assign o_valid           = r_vld_out;
    assign o_knee_radiance_1 = r_out_rad[0];
    assign o_knee_radiance_2 = r_out_rad[1];
    assign o_knee_radiance_3 = r_out_rad[2];
    assign o_knee_radiance_4 = r_out_rad[3];
    assign o_knee_count_1    = r_out_cnt[0];
    assign o_knee_count_2    = r_out_cnt[1];
    assign o_knee_count_3    = r_out_cnt[2];
    assign o_knee_count_4    = r_out_cnt[3];
    assign o_zero_slope_flag = r_out_zf;

    // The sort must deliver the radiances in ascending order.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_knee_radiance_1 <= o_knee_radiance_2) &&
                    (o_knee_radiance_2 <= o_knee_radiance_3) &&
                    (o_knee_radiance_3 <= o_knee_radiance_4))
        else $error("knee radiances out of order");

    // The pipeline only holds when a finished word waits at the output.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("pipeline held with an empty output");

    // Reset empties the whole pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_s1_vld && !r_s2_vld)
        else $error("valid bit survived reset");

endmodule

`default_nettype wire

// ===== rtl/dkc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage. The caller guarantees that
// the quotient fits in OFF_W + CFB bits, so the high part of the dividend
// starts out as the partial remainder.
module dkc_div import dkc_pkg::*; #(
    parameter int CFB = 8
) (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire  [RAD_W-1:0]             i_dvd,
    input  wire  [SLOPE_W-1:0]           i_dsr,
    output logic [OFF_W+CFB-1:0]         o_quo
);

    localparam int QW = OFF_W + CFB;

    logic [SLOPE_W-1:0] r_rem [0:QW-1];
    logic [QW-1:0]      r_low [0:QW-1];
    logic [SLOPE_W-1:0] r_dsr [0:QW-1];
    logic [QW-1:0]      r_quo [0:QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_dvd[RAD_W-1:OFF_W];
            r_low[0] <= QW'(i_dvd[OFF_W-1:0]) << CFB;
            r_dsr[0] <= i_dsr;
            r_quo[0] <= '0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [SLOPE_W:0]   n_trial;
        logic               n_ge;

        always_comb begin
            n_trial = {r_rem[k], r_low[k][QW-1]};
            n_ge    = (n_trial >= {1'b0, r_dsr[k]});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k+1] <= {r_quo[k][QW-2:0], n_ge};
            end
        end

        // The last stage only decides its quotient bit; the remainder is dropped.
        if (k < QW - 1) begin : g_fwd
            logic [SLOPE_W-1:0] n_diff;
            logic [SLOPE_W-1:0] n_rem;

            always_comb begin
                n_diff = n_trial[SLOPE_W-1:0] - r_dsr[k];
                n_rem  = n_ge ? n_diff : n_trial[SLOPE_W-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= n_rem;
                    r_low[k+1] <= r_low[k] << 1;
                    r_dsr[k+1] <= r_dsr[k];
                end
            end
        end
    end

    assign o_quo = r_quo[QW];

endmodule

`default_nettype wire

// ===== tb/sv/tb_detector_knee_calibration.sv =====
`timescale 1ns / 1ps

// Checks the knee calibration pipeline against a predictor of its own, with
// random idling on both sides and a long receiver hold-off.
module tb_detector_knee_calibration;
    import dkc_pkg::*;

    localparam int CFB = 8;
    localparam int LATENCY = CFB + 14;

    typedef struct {
        logic [OFF_W-1:0]   offset [N_DET];
        logic [SLOPE_W-1:0] slope [N_DET];
    } t_band_word;

    typedef struct {
        logic [RAD_W-1:0] rad [N_DET];
        logic [CNT_W-1:0] cnt [N_DET];
        logic             zflag;
    } t_knee_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_zero_slope_flag;
    logic [OFF_W-1:0]   offs [N_DET];
    logic [SLOPE_W-1:0] slps [N_DET];
    logic [RAD_W-1:0]   o_rad [N_DET];
    logic [CNT_W-1:0]   o_cnt [N_DET];

    t_band_word pending_words [$];
    t_knee_word expected_knees [$];
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int holdoff_cycles = 0;
    int mismatches = 0;
    int words_sent = 0;
    int words_checked = 0;
    int zero_flags_seen = 0;
    logic accepted_q = 1'b0;

    always #5 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < N_DET; i++) begin
            offs[i] = '0;
            slps[i] = '0;
        end
    end

    detector_knee_calibration #(.COUNT_FRAC_BITS(CFB)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_offset_det0(offs[0]), .i_offset_det1(offs[1]),
        .i_offset_det2(offs[2]), .i_offset_det3(offs[3]),
        .i_slope_det0(slps[0]), .i_slope_det1(slps[1]),
        .i_slope_det2(slps[2]), .i_slope_det3(slps[3]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_knee_radiance_1(o_rad[0]), .o_knee_radiance_2(o_rad[1]),
        .o_knee_radiance_3(o_rad[2]), .o_knee_radiance_4(o_rad[3]),
        .o_knee_count_1(o_cnt[0]), .o_knee_count_2(o_cnt[1]),
        .o_knee_count_3(o_cnt[2]), .o_knee_count_4(o_cnt[3]),
        .o_zero_slope_flag(o_zero_slope_flag)
    );

    // A quotient of a radiance by a slope gives a count with CFB
    // fraction bits; a zero divisor saturates to full scale.
    function automatic logic [63:0] knee_quotient(logic [63:0] rad, logic [63:0] slope);
        if (slope == 0) begin
            return 64'(1023) << CFB;
        end
        return (rad << CFB) / slope;
    endfunction

    function automatic t_knee_word predict_knees(t_band_word w);
        t_knee_word k;
        logic [63:0] sat [N_DET];
        logic [63:0] rad [N_DET];
        logic [63:0] s [N_DET];
        logic [63:0] g [N_DET];
        logic [63:0] c [N_DET];
        int ord [N_DET];
        int rank;
        for (int i = 0; i < N_DET; i++) begin
            sat[i] = 64'(1023 - int'(w.offset[i]));
            rad[i] = sat[i] * 64'(w.slope[i]);
        end
        // Stable sort by rank: equal radiances keep detector order.
        for (int i = 0; i < N_DET; i++) begin
            rank = 0;
            for (int j = 0; j < N_DET; j++)
                if (rad[j] < rad[i] || (rad[j] == rad[i] && j < i)) rank++;
            ord[rank] = i;
        end
        for (int i = 0; i < N_DET; i++) begin
            s[i] = sat[ord[i]] << CFB;
            g[i] = 64'(w.slope[ord[i]]);
        end
        c[0] = s[0] + knee_quotient(rad[ord[0]], g[1])
                    + knee_quotient(rad[ord[0]], g[2])
                    + knee_quotient(rad[ord[0]], g[3]);
        c[1] = s[0] + s[1] + knee_quotient(rad[ord[1]], g[2])
                    + knee_quotient(rad[ord[1]], g[3]);
        c[2] = s[0] + s[1] + s[2] + knee_quotient(rad[ord[2]], g[3]);
        c[3] = s[0] + s[1] + s[2] + s[3];
        for (int i = 0; i < N_DET; i++) begin
            k.rad[i] = rad[ord[i]][RAD_W-1:0];
            k.cnt[i] = c[i][CNT_W+1:2];
        end
        // Only the slopes that serve as divisors raise the flag.
        k.zflag = (g[1] == 0) || (g[2] == 0) || (g[3] == 0);
        return k;
    endfunction

    // Random band word: mostly full-range fields, with a share of zero
    // slopes, extreme offsets and deliberately tied radiances.
    function automatic t_band_word random_band_word();
        t_band_word w;
        for (int i = 0; i < N_DET; i++) begin
            case ($urandom_range(0, 9))
                0: w.offset[i] = $urandom_range(0, 1) ? 10'd0 : 10'd1023;
                1: w.offset[i] = OFF_W'($urandom_range(1000, 1023));
                default: w.offset[i] = OFF_W'($urandom_range(0, 1023));
            endcase
            case ($urandom_range(0, 11))
                0: w.slope[i] = '0;
                1: w.slope[i] = 24'hFFFFFF;
                2: w.slope[i] = SLOPE_W'($urandom_range(1, 16));
                default: w.slope[i] = SLOPE_W'($urandom_range(0, 24'hFFFFFF));
            endcase
        end
        if ($urandom_range(0, 7) == 0) begin
            w.offset[$urandom_range(0, 3)] = w.offset[0];
            w.slope[$urandom_range(1, 3)] = w.slope[0];
            w.offset[$urandom_range(1, 3)] = w.offset[0];
        end
        return w;
    endfunction

    function automatic t_band_word band_word(int o0, int o1, int o2, int o3,
                                             int g0, int g1, int g2, int g3);
        t_band_word w;
        w.offset[0] = OFF_W'(o0); w.offset[1] = OFF_W'(o1);
        w.offset[2] = OFF_W'(o2); w.offset[3] = OFF_W'(o3);
        w.slope[0] = SLOPE_W'(g0); w.slope[1] = SLOPE_W'(g1);
        w.slope[2] = SLOPE_W'(g2); w.slope[3] = SLOPE_W'(g3);
        return w;
    endfunction

    // Acceptance: the predictor runs on each word as the block takes it.
    always @(posedge i_clk) begin
        accepted_q <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_knees.push_back(predict_knees(pending_words[0]));
            void'(pending_words.pop_front());
            words_sent <= words_sent + 1;
        end
    end

    // Driver: presents the head of the pending queue and keeps it steady
    // while the block stalls. Inputs move on the falling edge.
    always @(negedge i_clk) begin
        t_band_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !accepted_q) begin
            // The word is still waiting for acceptance; hold it.
        end else if (pending_words.size() > 0 &&
                     $urandom_range(0, 99) >= sender_idle_pct) begin
            w = pending_words[0];
            for (int i = 0; i < N_DET; i++) begin
                offs[i] <= w.offset[i];
                slps[i] <= w.slope[i];
            end
            i_valid <= 1'b1;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver stall, with a long hold-off counted here when one is asked.
    always @(negedge i_clk) begin
        if (holdoff_cycles > 0) begin
            i_stall <= 1'b1;
            holdoff_cycles <= holdoff_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    // Monitor: every word that leaves is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_knee_word k;
        bit bad;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_knees.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("Unexpected output word at %0t", $time);
            end else begin
                k = expected_knees.pop_front();
                bad = (o_zero_slope_flag !== k.zflag);
                for (int i = 0; i < N_DET; i++)
                    bad |= (o_rad[i] !== k.rad[i]) || (o_cnt[i] !== k.cnt[i]);
                if (bad) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("Word %0d mismatch at %0t", words_checked, $time);
                        for (int i = 0; i < N_DET; i++)
                            $display("  knee %0d: radiance exp %0d got %0d, count exp %0d got %0d",
                                     i + 1, k.rad[i], o_rad[i], k.cnt[i], o_cnt[i]);
                        $display("  zero slope flag exp %0b got %0b", k.zflag, o_zero_slope_flag);
                    end
                end
                if (k.zflag) zero_flags_seen <= zero_flags_seen + 1;
                words_checked <= words_checked + 1;
            end
        end
    end

    task automatic drain_words();
        while (pending_words.size() > 0 || expected_knees.size() > 0) @(posedge i_clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) pending_words.push_back(random_band_word());
        drain_words();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: field extremes, zero slopes in every sorted slot,
        // full ties, and a zero slope on the smallest radiance only.
        pending_words.push_back(band_word(0, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        pending_words.push_back(band_word(1023, 1023, 1023, 1023, 0, 0, 0, 0));
        pending_words.push_back(band_word(0, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(band_word(100, 100, 100, 100, 5000, 5000, 5000, 5000));
        pending_words.push_back(band_word(0, 10, 20, 30, 0, 1, 2, 3));
        pending_words.push_back(band_word(0, 10, 20, 30, 4, 0, 2, 3));
        pending_words.push_back(band_word(1023, 0, 0, 0, 24'hFFFFFF, 1, 2, 3));
        pending_words.push_back(band_word(0, 0, 0, 0, 1, 2, 3, 4));
        pending_words.push_back(band_word(0, 0, 0, 0, 4, 3, 2, 1));
        pending_words.push_back(band_word(1, 2, 1022, 511, 1 << 20, 1 << 21, 24'hFFFFFF, 1));
        pending_words.push_back(band_word(1023, 0, 1023, 0, 24'h800000, 24'h7FFFFF, 1, 24'hAAAAAA));
        pending_words.push_back(band_word(682, 341, 1023, 0, 24'h555555, 24'hAAAAAA, 0, 24'hFFFFFF));
        pending_words.push_back(band_word(0, 1023, 0, 1023, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0));
        drain_words();

        run_phase(0, 0, 200);
        run_phase(50, 0, 200);
        run_phase(0, 50, 200);
        run_phase(17, 17, 200);

        // Long receiver hold-off while the sender keeps offering words, so the
        // pipeline fills and o_stall rises; afterwards the sender waits for
        // every result before going on.
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        holdoff_cycles = 4 * LATENCY;
        for (int n = 0; n < 100; n++) pending_words.push_back(random_band_word());
        drain_words();

        repeat (LATENCY + 5) @(posedge i_clk);
        $display("Sent %0d and checked %0d band words, %0d with a zero slope divisor,",
                 words_sent, words_checked, zero_flags_seen);
        $display("under no idling, sender gaps, receiver stalls, both, and a long hold-off.");
        if (mismatches == 0 && expected_knees.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end
endmodule
